/* rtl/mt_pkg.sv */
// MT19937 constants, widths and the tempering and twist functions.
// Stand-alone package; imported by the top level of the generator.
`timescale 1ns / 1ps

package mt_pkg;

    localparam int unsigned N_WORDS  = 624;
    localparam int unsigned M_OFFSET = 397;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned IDX_W    = $clog2(N_WORDS);
    localparam int unsigned POS_W    = 10;

    localparam logic [POS_W-1:0]  POS_FULL     = POS_W'(N_WORDS);
    localparam logic [POS_W-1:0]  POS_UNSEEDED = POS_W'(N_WORDS + 1);
    localparam logic [IDX_W-1:0]  IDX_LAST     = IDX_W'(N_WORDS - 1);
    localparam logic [IDX_W-1:0]  IDX_M_WRAP   = IDX_W'(N_WORDS - M_OFFSET);
    localparam logic [IDX_W-1:0]  IDX_M_FWD    = IDX_W'(M_OFFSET);

    localparam logic [WORD_W-1:0] INIT_MUL  = 32'd1812433253;
    localparam logic [WORD_W-1:0] MATRIX_A  = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] UPPER_MSK = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOWER_MSK = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C  = 32'hefc6_0000;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [POS_W-1:0]  t_pos;

    function automatic t_word temper(input t_word w);
        t_word y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic t_word twist_word(input t_word cur, input t_word nxt,
                                         input t_word far);
        t_word x;
        t_word xa;
        x  = (cur & UPPER_MSK) | (nxt & LOWER_MSK);
        xa = x >> 1;
        if (x[0]) begin
            xa = xa ^ MATRIX_A;
        end
        return far ^ xa;
    endfunction

endpackage

/* rtl/mt_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module mt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/mersenne_twister_prng.sv */
// MT19937 generator top level: request stream in, random word stream out.
// Depends on mt_pkg and two instances of mt_ram holding the state words.
`timescale 1ns / 1ps
//
// Usage
//   Slave stream carries requests: tuser = 0 seeds with tdata, tuser = 1 draws.
//   Master stream returns one transaction per draw: tdata is the tempered word,
//   tuser is high if the generator had been seeded, low (with zero data) if not.
//   A seed returns nothing; it rewrites all 624 state words, word 0 as the
//   request is taken and each later word in a multiply state, then an add
//   and write state; no new request is taken until the last word is written.
//   In a seeded draw the two state reads are issued as the request is taken;
//   the new word is twisted, written back and tempered in the state after.
//   The twist is done lazily, one word per draw, which gives the same sequence
//   as a full in-place twist. The old word at the draw position is kept in a
//   register, so the two copies of the state serve the other two reads.
//   An unseeded draw loads the output register as the request is taken.
//   Reset marks the generator unseeded; the state memories are not cleared.
//   The result waits in an output register; while it is not taken the block
//   accepts no new request.
//
module mersenne_twister_prng
    import mt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] seed_value
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] random_word
    output logic        m_axis_tuser    // [0] was_seeded
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SMUL  = 2'd1;
    localparam logic [1:0] ST_SADD  = 2'd2;
    localparam logic [1:0] ST_DCALC = 2'd3;

    localparam logic FUNC_SEED = 1'b0;

    logic [1:0] r_state, n_state;
    t_pos       r_pos, n_pos;
    t_idx       r_idx, n_idx;
    t_word      r_prev, n_prev;
    t_word      r_prod, n_prod;
    t_word      r_cur, n_cur;
    logic       r_out_vld, n_out_vld;
    t_word      r_out_word, n_out_word;
    logic       r_out_seeded, n_out_seeded;

    logic  accept;
    logic  seeded;
    t_idx  draw_idx;
    t_idx  nxt_addr;
    t_idx  far_addr;
    logic  mem_we;
    t_idx  mem_waddr;
    t_word mem_wdata;
    logic  mem_re;
    t_word rd_nxt;
    t_word rd_far;
    t_word seed_word;
    t_word new_word;

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_vld || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign seeded        = (r_pos <= POS_FULL);

    assign draw_idx  = (r_pos == POS_FULL) ? '0 : r_pos[IDX_W-1:0];
    assign nxt_addr  = (draw_idx == IDX_LAST) ? '0 : draw_idx + IDX_W'(1);
    assign far_addr  = (draw_idx >= IDX_M_WRAP) ? draw_idx - IDX_M_WRAP
                                                : draw_idx + IDX_M_FWD;

    assign seed_word = r_prod + t_word'(r_idx);
    assign new_word  = twist_word(r_cur, rd_nxt, rd_far);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = seed_word;
        mem_re    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept && s_axis_tuser == FUNC_SEED) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = s_axis_tdata;
                end else if (accept && seeded) begin
                    mem_re = 1'b1;
                end
            end
            ST_SADD: begin
                mem_we = 1'b1;
            end
            ST_DCALC: begin
                mem_we    = 1'b1;
                mem_wdata = new_word;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    mt_ram #(.WIDTH(WORD_W), .DEPTH(N_WORDS)) u_ram_nxt (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (nxt_addr),
        .o_rdata (rd_nxt)
    );

    mt_ram #(.WIDTH(WORD_W), .DEPTH(N_WORDS)) u_ram_far (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (far_addr),
        .o_rdata (rd_far)
    );

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_idx        = r_idx;
        n_prev       = r_prev;
        n_prod       = r_prod;
        n_cur        = r_cur;
        n_out_vld    = r_out_vld && !m_axis_tready;
        n_out_word   = r_out_word;
        n_out_seeded = r_out_seeded;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (s_axis_tuser == FUNC_SEED) begin
                        n_prev  = s_axis_tdata;
                        n_cur   = s_axis_tdata;
                        n_idx   = IDX_W'(1);
                        n_state = ST_SMUL;
                    end else if (seeded) begin
                        n_idx   = draw_idx;
                        n_state = ST_DCALC;
                    end else begin
                        n_out_vld    = 1'b1;
                        n_out_word   = '0;
                        n_out_seeded = 1'b0;
                    end
                end
            end
            ST_SMUL: begin
                n_prod  = (r_prev ^ (r_prev >> 30)) * INIT_MUL;
                n_state = ST_SADD;
            end
            ST_SADD: begin
                n_prev = seed_word;
                if (r_idx == IDX_LAST) begin
                    n_pos   = POS_FULL;
                    n_state = ST_IDLE;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = ST_SMUL;
                end
            end
            ST_DCALC: begin
                n_cur        = rd_nxt;
                n_pos        = POS_W'(r_idx) + POS_W'(1);
                n_out_vld    = 1'b1;
                n_out_word   = temper(new_word);
                n_out_seeded = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pos     <= POS_UNSEEDED;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_prev       <= n_prev;
        r_prod       <= n_prod;
        r_cur        <= n_cur;
        r_out_word   <= n_out_word;
        r_out_seeded <= n_out_seeded;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_word;
    assign m_axis_tuser  = r_out_seeded;

endmodule

/* sim/mt_tb_pkg.sv */
`timescale 1ns / 1ps
// Request codes for the MT19937 generator testbench, shared by the top and the checker.
// No dependencies.

package mt_tb_pkg;

    typedef enum logic {
        FUNC_SEED = 1'b0,
        FUNC_DRAW = 1'b1
    } req_func_e;

endpackage

/* sim/mt_checker.sv */
`timescale 1ns / 1ps
// Stream checker for mersenne_twister_prng: follows the request and result streams,
// keeps its own MT19937 state and compares every returned word. Needs mt_tb_pkg.

module mt_checker
    import mt_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_req_data,    // [31:0] seed_value
    input  logic        i_req_user,    // [0] func
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [31:0] i_rsp_data,    // [31:0] random_word
    input  logic        i_rsp_user,    // [0] was_seeded
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    localparam int          N_STATE   = 624;
    localparam int          M_SHIFT   = 397;
    localparam logic [9:0]  POS_NONE  = 10'd625;
    localparam logic [31:0] SEED_MUL  = 32'd1812433253;
    localparam logic [31:0] TW_MATRIX = 32'h9908_b0df;
    localparam logic [31:0] TW_UPPER  = 32'h8000_0000;
    localparam logic [31:0] TW_LOWER  = 32'h7fff_ffff;
    localparam logic [31:0] TMP_B     = 32'h9d2c_5680;
    localparam logic [31:0] TMP_C     = 32'hefc6_0000;

    typedef struct packed {
        logic [31:0] word;
        logic        seeded;
    } draw_t;

    logic [31:0] mt_words [N_STATE];
    logic [9:0]  mt_pos;
    draw_t       expected_draws [$];
    int          fail_count = 0;
    int          checked    = 0;

    function automatic logic [31:0] temper_word(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TMP_B);
        y = y ^ ((y << 15) & TMP_C);
        return y ^ (y >> 18);
    endfunction

    function automatic void seed_state(input logic [31:0] s);
        logic [31:0] prev;
        mt_words[0] = s;
        for (int i = 1; i < N_STATE; i++) begin
            prev        = mt_words[i-1];
            mt_words[i] = SEED_MUL * (prev ^ (prev >> 30)) + 32'(i);
        end
        mt_pos = 10'(N_STATE);
    endfunction

    function automatic void twist_state();
        logic [31:0] x;
        logic [31:0] xa;
        for (int i = 0; i < N_STATE; i++) begin
            x  = (mt_words[i] & TW_UPPER) | (mt_words[(i + 1) % N_STATE] & TW_LOWER);
            xa = x >> 1;
            if (x[0]) begin
                xa = xa ^ TW_MATRIX;
            end
            mt_words[i] = mt_words[(i + M_SHIFT) % N_STATE] ^ xa;
        end
        mt_pos = '0;
    endfunction

    function automatic void predict_request(input logic func, input logic [31:0] data);
        draw_t d;
        if (func == FUNC_SEED) begin
            seed_state(data);
        end else if (mt_pos > 10'(N_STATE)) begin
            d.word   = '0;
            d.seeded = 1'b0;
            expected_draws.push_back(d);
        end else begin
            if (mt_pos == 10'(N_STATE)) begin
                twist_state();
            end
            d.word   = temper_word(mt_words[mt_pos]);
            d.seeded = 1'b1;
            expected_draws.push_back(d);
            mt_pos = mt_pos + 10'd1;
        end
    endfunction

    always @(posedge i_clk) begin
        draw_t want;
        if (!i_rst_n) begin
            mt_pos = POS_NONE;
            expected_draws.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_draws.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("checker: unexpected result word=%08h seeded=%0b at %0t",
                                 i_rsp_data, i_rsp_user, $time);
                    end
                    fail_count++;
                end else begin
                    want = expected_draws.pop_front();
                    checked++;
                    if (want.word !== i_rsp_data || want.seeded !== i_rsp_user) begin
                        if (fail_count < 10) begin
                            $display({"checker: result %0d word exp %08h got %08h, ",
                                      "seeded exp %0b got %0b"},
                                     checked, want.word, i_rsp_data, want.seeded,
                                     i_rsp_user);
                        end
                        fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                predict_request(i_req_user, i_req_data);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_draws.size();
        o_checked    <= checked;
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Testbench top for mersenne_twister_prng: seed and draw requests under several
// idling modes, then the verdict. Needs mt_tb_pkg, mt_checker and the RTL.

module tb;
    import mt_tb_pkg::*;

    localparam int LIMIT = 800_000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_e;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    idle_mode_e  idle_mode  = IDLE_NONE;
    int          cycles     = 0;
    int          seeds_sent = 0;
    int          draws_sent = 0;
    int          fail_count;
    int          pending;
    int          checked;

    always #5 i_clk = ~i_clk;

    mersenne_twister_prng u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    mt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_user   (s_axis_tuser),
        .i_rsp_valid  (m_axis_tvalid),
        .i_rsp_ready  (m_axis_tready),
        .i_rsp_data   (m_axis_tdata),
        .i_rsp_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    function automatic int send_idle_pct(input idle_mode_e mode);
        case (mode)
            IDLE_SEND: return 61;
            IDLE_BOTH: return 23;
            default:   return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(input idle_mode_e mode);
        case (mode)
            IDLE_RECV: return 61;
            IDLE_BOTH: return 23;
            default:   return 0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct(idle_mode));
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: errors");
            $finish;
        end
    end

    // returns at the edge where the transaction is taken; valid is left high
    task automatic send_request(input req_func_e func, input logic [31:0] data);
        while ($urandom_range(0, 99) < send_idle_pct(idle_mode)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        if (func == FUNC_SEED) begin
            seeds_sent++;
        end else begin
            draws_sent++;
        end
    endtask

    task automatic send_draws(input int count);
        for (int k = 0; k < count; k++) begin
            send_request(FUNC_DRAW, $urandom());
        end
    endtask

    task automatic random_requests(input int count, input int seed_one_in);
        for (int k = 0; k < count; k++) begin
            if (seed_one_in > 0 && $urandom_range(0, seed_one_in - 1) == 0) begin
                send_request(FUNC_SEED, $urandom());
            end else begin
                send_request(FUNC_DRAW, $urandom());
            end
        end
    endtask

    // sender holds off until every outstanding word has been returned
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unseeded draws, then seeds at the extremes
        send_request(FUNC_DRAW, 32'hffff_ffff);
        send_request(FUNC_DRAW, 32'h0000_0000);
        send_request(FUNC_DRAW, $urandom());
        send_request(FUNC_SEED, 32'd5489);
        send_draws(6);
        send_request(FUNC_SEED, 32'h0000_0000);
        send_draws(3);
        send_request(FUNC_SEED, 32'hffff_ffff);
        send_draws(3);
        send_request(FUNC_SEED, 32'h8000_0000);
        send_request(FUNC_SEED, 32'h7fff_ffff);
        send_draws(2);
        wait_results();

        idle_mode <= IDLE_NONE;
        random_requests(300, 100);
        wait_results();

        idle_mode <= IDLE_SEND;
        random_requests(300, 100);
        wait_results();

        // one long run from a fresh seed through two twists
        idle_mode <= IDLE_RECV;
        send_request(FUNC_SEED, $urandom());
        send_draws(699);
        wait_results();

        idle_mode <= IDLE_BOTH;
        random_requests(200, 100);
        wait_results();

        repeat (20) @(posedge i_clk);
        $display("summary: %0d seeds and %0d draws sent, %0d words checked", seeds_sent,
                 draws_sent, checked);
        $display("summary: unseeded draws, extreme seeds, a run past two twists, four idle modes");
        if (fail_count == 0 && pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
